FILE: rtl/tvgs_pkg.sv
// ----------------------------------------------------------------------------
// tvgs_pkg
// Shared types and codes for the timed valve group scheduler.
// ----------------------------------------------------------------------------
package tvgs_pkg;

   localparam int MaskW = 64;
   localparam int TimeW = 32;
   localparam int LocW  = 8;

   localparam logic KIND_CMD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_REQ_RUN  = 2'd1,
      PH_RUNNING  = 2'd2,
      PH_REQ_STOP = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_START  = 2'd1,
      EV_FINISH = 2'd2
   } event_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD_RD,
      ST_CMD_EX,
      ST_CMD_NEW,
      ST_TICK_RD,
      ST_TICK_EX,
      ST_SCAN_RD,
      ST_SCAN_EX,
      ST_STOP_OUT,
      ST_FINAL_OUT
   } state_type;

   // classified item as it sits in the queue
   typedef struct packed {
      logic             kind;
      logic [LocW-1:0]  location;
      phase_type        phase;
      logic [TimeW-1:0] now;
      logic [TimeW-1:0] stop;
      logic [MaskW-1:0] valves;
   } item_type;

endpackage

FILE: rtl/timed_valve_group_scheduler.sv
// ----------------------------------------------------------------------------
// timed_valve_group_scheduler
// Table of timed valve groups: commands load entries, ticks walk them.
// ----------------------------------------------------------------------------
// Command: checks each entry in turn, loads a free one if none matched, then
// gives the result. Tick: walks all entries, with an overlap scan for each
// stopping entry; output stalls hold it. The entry table has a single read
// port; one item in work at a time, a two-deep queue takes the next items.
// Reset clears entry live bits, port state and control; no clearing pass.
module timed_valve_group_scheduler import tvgs_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [LocW-1:0]  req_location,
   input  logic [TimeW-1:0] req_duration,
   input  logic [MaskW-1:0] req_valves,
   input  logic [TimeW-1:0] req_now,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_event_res,
   output logic [LocW-1:0]  rsp_event_location,
   output logic [TimeW-1:0] rsp_elapsed,
   output logic [MaskW-1:0] rsp_port_state,
   output logic             rsp_pump_on,
   output logic             rsp_last
);

   logic     q_valid, q_ready;
   item_type q_item;

   tvgs_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_location (req_location),
      .req_duration (req_duration),
      .req_valves   (req_valves),
      .req_now      (req_now),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item)
   );

   tvgs_back #(.ENTRIES(ENTRIES)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_ready            (q_ready),
      .q_item             (q_item),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_event_res      (rsp_event_res),
      .rsp_event_location (rsp_event_location),
      .rsp_elapsed        (rsp_elapsed),
      .rsp_port_state     (rsp_port_state),
      .rsp_pump_on        (rsp_pump_on),
      .rsp_last           (rsp_last)
   );

endmodule

FILE: rtl/tvgs_front.sv
// ----------------------------------------------------------------------------
// tvgs_front
// Accepts items, works out the requested phase and stop time, and queues
// them for the back end in a two-deep queue.
// ----------------------------------------------------------------------------
module tvgs_front import tvgs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_kind,
   input  logic [LocW-1:0]  req_location,
   input  logic [TimeW-1:0] req_duration,
   input  logic [MaskW-1:0] req_valves,
   input  logic [TimeW-1:0] req_now,
   output logic             q_valid,
   input  logic             q_ready,
   output item_type         q_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   item_type   new_item;
   logic       push, pop;

   always_comb begin
      new_item.kind     = req_kind;
      new_item.location = req_location;
      new_item.phase    = (req_duration != '0) ? PH_REQ_RUN : PH_REQ_STOP;
      new_item.now      = req_now;
      new_item.stop     = req_now + req_duration;
      new_item.valves   = req_valves;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: rtl/tvgs_back.sv
// ----------------------------------------------------------------------------
// tvgs_back
// Carries out queued items against the entry table, one entry per step,
// and drives results through an output register.
// ----------------------------------------------------------------------------
module tvgs_back import tvgs_pkg::*; #(
   parameter int ENTRIES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   output logic             q_ready,
   input  item_type         q_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_event_res,
   output logic [LocW-1:0]  rsp_event_location,
   output logic [TimeW-1:0] rsp_elapsed,
   output logic [MaskW-1:0] rsp_port_state,
   output logic             rsp_pump_on,
   output logic             rsp_last
);

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

   // entry table
   logic [LocW-1:0]  loc_mem   [ENTRIES];
   logic [1:0]       phase_mem [ENTRIES];
   logic [TimeW-1:0] start_mem [ENTRIES];
   logic [TimeW-1:0] stop_mem  [ENTRIES];
   logic [MaskW-1:0] mask_mem  [ENTRIES];

   logic [LocW-1:0]  rd_loc_ff;
   logic [1:0]       rd_phase_ff;
   logic [TimeW-1:0] rd_start_ff;
   logic [TimeW-1:0] rd_stop_ff;
   logic [MaskW-1:0] rd_mask_ff;

   logic [ENTRIES-1:0] live_ff, live_in;

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [IW-1:0]    scan_ff, scan_in;
   logic             found_ff, found_in;
   logic [MaskW-1:0] ports_on_ff, ports_on_in;
   logic [MaskW-1:0] ports_ff, ports_in;
   logic [MaskW-1:0] shared_ff, shared_in;
   logic [MaskW-1:0] own_mask_ff, own_mask_in;
   logic [TimeW-1:0] own_start_ff, own_start_in;
   logic [LocW-1:0]  own_loc_ff, own_loc_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_ev_ff, out_ev_in;
   logic [LocW-1:0]  out_loc_ff, out_loc_in;
   logic [TimeW-1:0] out_el_ff, out_el_in;
   logic [MaskW-1:0] out_ports_ff, out_ports_in;
   logic             out_last_ff, out_last_in;

   logic             load_we, phase_we;
   logic [IW-1:0]    wr_addr;
   logic [1:0]       phase_wd;
   logic [IW-1:0]    rd_addr;
   logic             have_free;
   logic [IW-1:0]    free_idx;
   logic             out_free;
   logic [MaskW-1:0] stop_ports;

   always_comb begin
      have_free = 1'b0;
      free_idx  = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            have_free = 1'b1;
            free_idx  = IW'(i);
         end
      end
   end

   assign out_free   = !out_valid_ff || rsp_ready;
   assign rd_addr    = (state_ff == ST_SCAN_RD || state_ff == ST_SCAN_EX) ? scan_ff : idx_ff;
   assign stop_ports = ports_ff & ~(own_mask_ff & ~shared_ff);
   assign q_ready    = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      ports_on_in  = ports_on_ff;
      ports_in     = ports_ff;
      shared_in    = shared_ff;
      own_mask_in  = own_mask_ff;
      own_start_in = own_start_ff;
      own_loc_in   = own_loc_ff;
      live_in      = live_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_ev_in    = out_ev_ff;
      out_loc_in   = out_loc_ff;
      out_el_in    = out_el_ff;
      out_ports_in = out_ports_ff;
      out_last_in  = out_last_ff;
      load_we      = 1'b0;
      phase_we     = 1'b0;
      wr_addr      = idx_ff;
      phase_wd     = item_ff.phase;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in  = q_item;
               idx_in   = '0;
               found_in = 1'b0;
               ports_in = ports_on_ff;
               state_in = (q_item.kind == KIND_TICK) ? ST_TICK_RD : ST_CMD_RD;
            end
         end
         ST_CMD_RD: state_in = ST_CMD_EX;
         ST_CMD_EX: begin
            if (live_ff[idx_ff] && rd_loc_ff == item_ff.location) begin
               load_we  = 1'b1;
               found_in = 1'b1;
            end
            if (idx_ff == LastIdx) begin
               state_in = ST_CMD_NEW;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_CMD_RD;
            end
         end
         ST_CMD_NEW: begin
            if (!found_ff && item_ff.location != '0 && have_free) begin
               load_we           = 1'b1;
               wr_addr           = free_idx;
               live_in[free_idx] = 1'b1;
            end
            state_in = ST_FINAL_OUT;
         end
         ST_TICK_RD: state_in = ST_TICK_EX;
         ST_TICK_EX: begin
            if (live_ff[idx_ff] && rd_phase_ff == PH_REQ_STOP) begin
               own_mask_in  = rd_mask_ff;
               own_start_in = rd_start_ff;
               own_loc_in   = rd_loc_ff;
               shared_in    = '0;
               scan_in      = '0;
               state_in     = ST_SCAN_RD;
            end else if (live_ff[idx_ff] && rd_phase_ff == PH_REQ_RUN) begin
               if (out_free) begin
                  phase_we     = 1'b1;
                  phase_wd     = PH_RUNNING;
                  ports_in     = ports_ff | rd_mask_ff;
                  out_valid_in = 1'b1;
                  out_ev_in    = EV_START;
                  out_loc_in   = rd_loc_ff;
                  out_el_in    = '0;
                  out_ports_in = ports_ff | rd_mask_ff;
                  out_last_in  = 1'b0;
                  idx_in       = idx_ff + 1'b1;
                  state_in     = (idx_ff == LastIdx) ? ST_FINAL_OUT : ST_TICK_RD;
               end
            end else begin
               if (live_ff[idx_ff] && rd_phase_ff == PH_RUNNING) begin
                  ports_in = ports_ff | rd_mask_ff;
                  if (item_ff.now >= rd_stop_ff) begin
                     phase_we = 1'b1;
                     phase_wd = PH_REQ_STOP;
                  end
               end
               idx_in   = idx_ff + 1'b1;
               state_in = (idx_ff == LastIdx) ? ST_FINAL_OUT : ST_TICK_RD;
            end
         end
         ST_SCAN_RD: state_in = ST_SCAN_EX;
         ST_SCAN_EX: begin
            if (scan_ff != idx_ff && live_ff[scan_ff]) begin
               shared_in = shared_ff | rd_mask_ff;
            end
            if (scan_ff == LastIdx) begin
               state_in = ST_STOP_OUT;
            end else begin
               scan_in  = scan_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_STOP_OUT: begin
            if (out_free) begin
               ports_in        = stop_ports;
               live_in[idx_ff] = 1'b0;
               phase_we        = 1'b1;
               phase_wd        = PH_IDLE;
               out_valid_in    = 1'b1;
               out_ev_in       = EV_FINISH;
               out_loc_in      = own_loc_ff;
               out_el_in       = item_ff.now - own_start_ff;
               out_ports_in    = stop_ports;
               out_last_in     = 1'b0;
               idx_in          = idx_ff + 1'b1;
               state_in        = (idx_ff == LastIdx) ? ST_FINAL_OUT : ST_TICK_RD;
            end
         end
         ST_FINAL_OUT: begin
            if (out_free) begin
               ports_on_in  = ports_ff;
               out_valid_in = 1'b1;
               out_ev_in    = EV_NONE;
               out_loc_in   = '0;
               out_el_in    = '0;
               out_ports_in = ports_ff;
               out_last_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         live_ff      <= '0;
         ports_on_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         live_ff      <= live_in;
         ports_on_ff  <= ports_on_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      idx_ff       <= idx_in;
      scan_ff      <= scan_in;
      found_ff     <= found_in;
      ports_ff     <= ports_in;
      shared_ff    <= shared_in;
      own_mask_ff  <= own_mask_in;
      own_start_ff <= own_start_in;
      own_loc_ff   <= own_loc_in;
      out_ev_ff    <= out_ev_in;
      out_loc_ff   <= out_loc_in;
      out_el_ff    <= out_el_in;
      out_ports_ff <= out_ports_in;
      out_last_ff  <= out_last_in;
   end

   // entry memories: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_we) begin
         loc_mem[wr_addr]   <= item_ff.location;
         start_mem[wr_addr] <= item_ff.now;
         stop_mem[wr_addr]  <= item_ff.stop;
         mask_mem[wr_addr]  <= item_ff.valves;
      end
      if (load_we || phase_we) begin
         phase_mem[wr_addr] <= phase_wd;
      end
      rd_loc_ff   <= loc_mem[rd_addr];
      rd_phase_ff <= phase_mem[rd_addr];
      rd_start_ff <= start_mem[rd_addr];
      rd_stop_ff  <= stop_mem[rd_addr];
      rd_mask_ff  <= mask_mem[rd_addr];
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_res      = out_ev_ff;
   assign rsp_event_location = out_loc_ff;
   assign rsp_elapsed        = out_el_ff;
   assign rsp_port_state     = out_ports_ff;
   assign rsp_pump_on        = (out_ports_ff != '0);
   assign rsp_last           = out_last_ff;

   a_last_no_event: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_last_ff |-> out_ev_ff == EV_NONE)
      else $error("final result carries an event");

   a_none_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ev_ff == EV_NONE |-> out_loc_ff == '0 && out_el_ff == '0)
      else $error("empty event with location or elapsed set");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_valid && q_ready |=> state_ff != ST_IDLE)
      else $error("item taken but back end stayed idle");

   a_event_loc: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ev_ff != EV_NONE |-> out_loc_ff != '0)
      else $error("event for location zero");

endmodule
